FILE: hw/rtl/gpsc_pkg.sv
// gpsc_pkg: shared widths, codes and beat structs of the grid point surface classifier
// no dependencies
`default_nettype none

package gpsc_pkg;

  localparam int MaxLinesDefault = 64;

  localparam int CmdW     = 2;
  localparam int LineIdxW = 6;
  localparam int CoordW   = 32;
  localparam int OctW     = 3;
  localparam int CellsW   = 6;
  localparam int TolW     = 16;
  localparam int OutIdxW  = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  typedef enum logic [CmdW-1:0] {
    CmdWrX   = 2'd0,
    CmdWrY   = 2'd1,
    CmdQuery = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    SurfE = 2'd0,
    SurfW = 2'd1,
    SurfN = 2'd2,
    SurfS = 2'd3
  } surf_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgXCells = 2'd0,
    CfgYCells = 2'd1,
    CfgTol    = 2'd2
  } cfg_e;

  localparam logic [OctW-1:0] OctPxPy = 3'd1;
  localparam logic [OctW-1:0] OctNxPy = 3'd2;
  localparam logic [OctW-1:0] OctNxNy = 3'd3;
  localparam logic [OctW-1:0] OctPxNy = 3'd4;

  localparam logic [CellsW-1:0] XCellsReset = 6'd1;
  localparam logic [CellsW-1:0] YCellsReset = 6'd1;
  localparam logic [TolW-1:0]   TolReset    = 16'd16;

  typedef struct packed {
    logic [CmdW-1:0]     cmd;
    logic [LineIdxW-1:0] line_index;
    logic [CoordW-1:0]   line_value;
    logic [CoordW-1:0]   point_x;
    logic [CoordW-1:0]   point_y;
    logic [OctW-1:0]     octant;
  } beat_t;

  typedef struct packed {
    logic x_done;
    logic x_on;
    logic y_done;
    logic y_on;
  } scan_t;

  typedef struct packed {
    logic [CellsW-1:0] x_cells;
    logic [CellsW-1:0] y_cells;
    logic [TolW-1:0]   tol;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                count;
    logic [1:0]                first;
    logic [1:0]                second;
    logic signed [OutIdxW-1:0] x_idx;
    logic signed [OutIdxW-1:0] y_idx;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gpsc_if.sv
// gpsc_in_if / gpsc_out_if: valid/ready channels for command beats and result beats
// depends on gpsc_pkg
`default_nettype none

interface gpsc_in_if;
  logic                            valid;
  logic                            ready;
  logic [gpsc_pkg::CmdW-1:0]       cmd;
  logic [gpsc_pkg::LineIdxW-1:0]   line_index;
  logic [gpsc_pkg::CoordW-1:0]     line_value;
  logic [gpsc_pkg::CoordW-1:0]     point_x;
  logic [gpsc_pkg::CoordW-1:0]     point_y;
  logic [gpsc_pkg::OctW-1:0]       octant;

  modport source (output valid, cmd, line_index, line_value, point_x, point_y, octant,
                  input ready);
  modport sink (input valid, cmd, line_index, line_value, point_x, point_y, octant,
                output ready);
endinterface

interface gpsc_out_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          surface_count;
  logic [1:0]                          first_surface;
  logic [1:0]                          second_surface;
  logic signed [gpsc_pkg::OutIdxW-1:0] x_line_index;
  logic signed [gpsc_pkg::OutIdxW-1:0] y_line_index;

  modport source (output valid, surface_count, first_surface, second_surface,
                  x_line_index, y_line_index, input ready);
  modport sink (input valid, surface_count, first_surface, second_surface,
                x_line_index, y_line_index, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/gpsc_cell.sv
// gpsc_cell: one link of the search chain, holds x and y grid line entry Index
// depends on gpsc_pkg
`default_nettype none

module gpsc_cell #(
  parameter int Index = 0,
  parameter int IdxW  = 8
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          en_i,
  input  gpsc_pkg::cfg_t               cfg_i,
  input  wire                          vld_i,
  input  gpsc_pkg::beat_t              beat_i,
  input  gpsc_pkg::scan_t              scan_i,
  input  wire  logic signed [IdxW-1:0] x_idx_i,
  input  wire  logic signed [IdxW-1:0] y_idx_i,
  output logic                         vld_o,
  output gpsc_pkg::beat_t              beat_o,
  output gpsc_pkg::scan_t              scan_o,
  output logic signed [IdxW-1:0]       x_idx_o,
  output logic signed [IdxW-1:0]       y_idx_o
);

  localparam logic signed [IdxW-1:0] IdxHere = IdxW'(Index);
  localparam logic signed [IdxW-1:0] IdxLow  = IdxW'(Index - 1);
  localparam logic signed [IdxW-1:0] IdxHigh = IdxW'(Index + 1);

  logic [gpsc_pkg::CoordW-1:0] x_line_q, y_line_q;
  logic                        vld_q;
  gpsc_pkg::beat_t             beat_q;
  gpsc_pkg::scan_t             scan_q, scan_d;
  logic signed [IdxW-1:0]      x_idx_q, x_idx_d, y_idx_q, y_idx_d;
  logic [1:0]                  x_probe, y_probe;
  logic                        is_query, x_active, y_active;

  // {hit, above}
  function automatic logic [1:0] probe(input logic [gpsc_pkg::CoordW-1:0] p,
                                       input logic [gpsc_pkg::CoordW-1:0] v,
                                       input logic [gpsc_pkg::TolW-1:0]   tol);
    logic [gpsc_pkg::CoordW-1:0] diff;
    diff = (p >= v) ? (p - v) : (v - p);
    return {diff <= gpsc_pkg::CoordW'(tol), v > p};
  endfunction

  always_comb begin
    is_query = (beat_i.cmd == gpsc_pkg::CmdQuery);
    x_active = (Index <= int'(cfg_i.x_cells));
    y_active = (Index <= int'(cfg_i.y_cells));
    x_probe  = probe(beat_i.point_x, x_line_q, cfg_i.tol);
    y_probe  = probe(beat_i.point_y, y_line_q, cfg_i.tol);
    scan_d   = scan_i;
    x_idx_d  = x_idx_i;
    y_idx_d  = y_idx_i;
    if (is_query && x_active && !scan_i.x_done) begin
      if (x_probe[1]) begin
        scan_d.x_on   = 1'b1;
        scan_d.x_done = 1'b1;
        x_idx_d       = IdxHere;
      end else if (x_probe[0]) begin
        scan_d.x_done = 1'b1;
        x_idx_d       = IdxLow;
      end else begin
        x_idx_d = IdxHigh;
      end
    end
    if (is_query && y_active && !scan_i.y_done) begin
      if (y_probe[1]) begin
        scan_d.y_on   = 1'b1;
        scan_d.y_done = 1'b1;
        y_idx_d       = IdxHere;
      end else if (y_probe[0]) begin
        scan_d.y_done = 1'b1;
        y_idx_d       = IdxLow;
      end else begin
        y_idx_d = IdxHigh;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      beat_q  <= beat_i;
      scan_q  <= scan_d;
      x_idx_q <= x_idx_d;
      y_idx_q <= y_idx_d;
      if (vld_i && beat_i.cmd == gpsc_pkg::CmdWrX && int'(beat_i.line_index) == Index) begin
        x_line_q <= beat_i.line_value;
      end
      if (vld_i && beat_i.cmd == gpsc_pkg::CmdWrY && int'(beat_i.line_index) == Index) begin
        y_line_q <= beat_i.line_value;
      end
    end
  end

  assign vld_o   = vld_q;
  assign beat_o  = beat_q;
  assign scan_o  = scan_q;
  assign x_idx_o = x_idx_q;
  assign y_idx_o = y_idx_q;

endmodule

`default_nettype wire

FILE: hw/rtl/gpsc_classify.sv
// gpsc_classify: turns line indices and on-line flags into outgoing surfaces
// depends on gpsc_pkg
`default_nettype none

module gpsc_classify #(
  parameter int IdxW = 8
) (
  input  gpsc_pkg::cfg_t               cfg_i,
  input  gpsc_pkg::beat_t              beat_i,
  input  gpsc_pkg::scan_t              scan_i,
  input  wire  logic signed [IdxW-1:0] x_idx_i,
  input  wire  logic signed [IdxW-1:0] y_idx_i,
  output gpsc_pkg::res_t               res_o
);

  localparam int CmpW = (IdxW > gpsc_pkg::CellsW + 1) ? IdxW : gpsc_pkg::CellsW + 1;
  localparam int ExtW = (CmpW > gpsc_pkg::OutIdxW) ? CmpW : gpsc_pkg::OutIdxW;
  localparam logic signed [CmpW-1:0] Zero = '0;

  logic signed [CmpW-1:0] ix, iy, nx, ny;
  logic signed [ExtW-1:0] ix_ext, iy_ext;
  logic                   is_query, oct_ok, px, py, on_x, on_y;
  logic [1:0]             cnt;
  gpsc_pkg::surf_e        s0, s1;

  always_comb begin
    ix       = CmpW'(x_idx_i);
    iy       = CmpW'(y_idx_i);
    nx       = signed'(CmpW'(cfg_i.x_cells));
    ny       = signed'(CmpW'(cfg_i.y_cells));
    ix_ext   = ExtW'(x_idx_i);
    iy_ext   = ExtW'(y_idx_i);
    is_query = (beat_i.cmd == gpsc_pkg::CmdQuery);
    oct_ok   = beat_i.octant inside {[gpsc_pkg::OctPxPy:gpsc_pkg::OctPxNy]};
    px       = beat_i.octant inside {gpsc_pkg::OctPxPy, gpsc_pkg::OctPxNy};
    py       = beat_i.octant inside {gpsc_pkg::OctPxPy, gpsc_pkg::OctNxPy};
    on_x     = scan_i.x_on;
    on_y     = scan_i.y_on;
    cnt      = 2'd0;
    s0       = gpsc_pkg::SurfE;
    s1       = gpsc_pkg::SurfE;
    if (is_query && oct_ok && (on_x || on_y)) begin
      if (on_x != on_y) begin
        cnt = 2'd1;
        if (on_x) begin
          if (ix == Zero && px) begin
            s0 = gpsc_pkg::SurfW;
          end else if (ix == nx && !px) begin
            s0 = gpsc_pkg::SurfE;
          end else begin
            s0 = px ? gpsc_pkg::SurfE : gpsc_pkg::SurfW;
          end
        end else begin
          if (iy == Zero && py) begin
            s0 = gpsc_pkg::SurfS;
          end else if (iy == ny && !py) begin
            s0 = gpsc_pkg::SurfN;
          end else begin
            s0 = py ? gpsc_pkg::SurfN : gpsc_pkg::SurfS;
          end
        end
      end else if (ix > Zero && ix < nx && iy > Zero && iy < ny) begin
        cnt = 2'd2;
        s0  = px ? gpsc_pkg::SurfE : gpsc_pkg::SurfW;
        s1  = py ? gpsc_pkg::SurfN : gpsc_pkg::SurfS;
      end else if (ix == Zero) begin
        if (px) begin
          cnt = 2'd1;
          s0  = gpsc_pkg::SurfW;
        end else begin
          cnt = 2'd2;
          s0  = py ? gpsc_pkg::SurfN : gpsc_pkg::SurfS;
          s1  = gpsc_pkg::SurfW;
        end
      end else if (ix == nx) begin
        if (!px) begin
          cnt = 2'd1;
          s0  = gpsc_pkg::SurfE;
        end else begin
          cnt = 2'd2;
          s0  = py ? gpsc_pkg::SurfN : gpsc_pkg::SurfS;
          s1  = gpsc_pkg::SurfE;
        end
      end else if (iy == Zero) begin
        if (py) begin
          cnt = 2'd1;
          s0  = gpsc_pkg::SurfS;
        end else begin
          cnt = 2'd2;
          s0  = px ? gpsc_pkg::SurfE : gpsc_pkg::SurfW;
          s1  = gpsc_pkg::SurfS;
        end
      end else if (iy == ny) begin
        if (!py) begin
          cnt = 2'd1;
          s0  = gpsc_pkg::SurfN;
        end else begin
          cnt = 2'd2;
          s0  = px ? gpsc_pkg::SurfE : gpsc_pkg::SurfW;
          s1  = gpsc_pkg::SurfN;
        end
      end
    end
    res_o.count  = cnt;
    res_o.first  = s0;
    res_o.second = s1;
    res_o.x_idx  = is_query ? ix_ext[gpsc_pkg::OutIdxW-1:0] : '0;
    res_o.y_idx  = is_query ? iy_ext[gpsc_pkg::OutIdxW-1:0] : '0;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/grid_point_surface_classifier_top.sv
// grid_point_surface_classifier_top: chain of line cells, surface classifier, result register
// depends on gpsc_pkg, gpsc_if, gpsc_cell, gpsc_classify
//
//   port        dir   kind           carries
//   in_i        in    valid/ready    line writes and point queries
//   out_o       out   valid/ready    surface count, surfaces, line indices
//   cfg_*_i     in    write strobe   x_cells, y_cells, match_tolerance
//
// one beat per cycle sustained unless out_o stalls; a beat walks the MaxLines cells in order,
// then lands in the result register
// each cell holds x and y entry of its own index; writes travel the chain in order
// a stalled result beat freezes the whole chain; in_i.ready is high when out_o.ready is or out_o.valid is low
// reset clears valid bits and sets config to its reset values; line entries hold garbage until written
`default_nettype none

module grid_point_surface_classifier_top #(
  parameter int MaxLines = gpsc_pkg::MaxLinesDefault
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  gpsc_in_if.sink                             in_i,
  gpsc_out_if.source                          out_o,
  input  wire                                 cfg_we_i,
  input  wire  [gpsc_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire  [gpsc_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int IdxW = $clog2(MaxLines + 1) + 1;

  gpsc_pkg::cfg_t         cfg_q;
  logic                   advance;
  logic                   vld_c  [MaxLines+1];
  gpsc_pkg::beat_t        beat_c [MaxLines+1];
  gpsc_pkg::scan_t        scan_c [MaxLines+1];
  logic signed [IdxW-1:0] xi_c   [MaxLines+1];
  logic signed [IdxW-1:0] yi_c   [MaxLines+1];
  gpsc_pkg::res_t         res, res_q;
  logic                   out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_cells <= gpsc_pkg::XCellsReset;
      cfg_q.y_cells <= gpsc_pkg::YCellsReset;
      cfg_q.tol     <= gpsc_pkg::TolReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gpsc_pkg::CfgXCells: cfg_q.x_cells <= cfg_data_i[gpsc_pkg::CellsW-1:0];
        gpsc_pkg::CfgYCells: cfg_q.y_cells <= cfg_data_i[gpsc_pkg::CellsW-1:0];
        gpsc_pkg::CfgTol:    cfg_q.tol     <= cfg_data_i[gpsc_pkg::TolW-1:0];
        default: ;
      endcase
    end
  end

  assign advance   = !out_vld_q || out_o.ready;
  assign in_i.ready = advance;

  assign vld_c[0]             = in_i.valid;
  assign beat_c[0].cmd        = in_i.cmd;
  assign beat_c[0].line_index = in_i.line_index;
  assign beat_c[0].line_value = in_i.line_value;
  assign beat_c[0].point_x    = in_i.point_x;
  assign beat_c[0].point_y    = in_i.point_y;
  assign beat_c[0].octant     = in_i.octant;
  assign scan_c[0]            = '0;
  assign xi_c[0]              = '0;
  assign yi_c[0]              = '0;

  for (genvar g = 0; g < MaxLines; g++) begin : g_cell
    gpsc_cell #(
      .Index (g),
      .IdxW  (IdxW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .cfg_i   (cfg_q),
      .vld_i   (vld_c[g]),
      .beat_i  (beat_c[g]),
      .scan_i  (scan_c[g]),
      .x_idx_i (xi_c[g]),
      .y_idx_i (yi_c[g]),
      .vld_o   (vld_c[g+1]),
      .beat_o  (beat_c[g+1]),
      .scan_o  (scan_c[g+1]),
      .x_idx_o (xi_c[g+1]),
      .y_idx_o (yi_c[g+1])
    );
  end

  gpsc_classify #(
    .IdxW (IdxW)
  ) u_classify (
    .cfg_i   (cfg_q),
    .beat_i  (beat_c[MaxLines]),
    .scan_i  (scan_c[MaxLines]),
    .x_idx_i (xi_c[MaxLines]),
    .y_idx_i (yi_c[MaxLines]),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= vld_c[MaxLines];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.surface_count  = res_q.count;
  assign out_o.first_surface  = res_q.first;
  assign out_o.second_surface = res_q.second;
  assign out_o.x_line_index   = res_q.x_idx;
  assign out_o.y_line_index   = res_q.y_idx;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> res_q.count != 2'd3)
    else $error("surface count out of range");

  a_second_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.count != 2'd2 |-> res_q.second == 2'd0)
    else $error("second surface set without a second face");

  a_two_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.count == 2'd2 |-> res_q.first != res_q.second)
    else $error("two surfaces reported are the same face");

  a_chain_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(vld_c[MaxLines]) && $stable(res_q))
    else $error("chain moved during a stall");
`endif

endmodule

`default_nettype wire
